>>> rtl/core/tfci_pkg.sv
// types, constants and class mapping helpers for the tlsf free class index engine
package tfci_pkg;

    localparam int NUM_FL      = 32;
    localparam int NUM_SL      = 16;
    localparam int FL_BITS     = 5;
    localparam int SL_BITS     = 4;
    localparam int ALIGN_BITS  = 3;
    localparam int SIZE_W      = 38;
    localparam int ADDR_W      = 32;
    localparam int IDX_W       = FL_BITS + SL_BITS;
    localparam int MIN_BLOCK   = 24;
    localparam int CLASS0_BITS = SL_BITS + ALIGN_BITS;

    localparam logic [63:0] LIMIT_WIDE =
        (64'd1 << (NUM_FL + SL_BITS + ALIGN_BITS - 2)) - (64'd1 << ALIGN_BITS);
    localparam logic [SIZE_W-1:0] SIZE_LIMIT = LIMIT_WIDE[SIZE_W-1:0];

    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FREE   = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;

    // first level carries one spare bit to flag a class past the table
    typedef struct packed {
        logic [FL_BITS:0]   fl;
        logic [SL_BITS-1:0] sl;
    } class_t;

    // size to class, optionally rounding up to the start of the next class
    function automatic class_t map_class(input logic [SIZE_W-1:0] v, input logic round_up);
        class_t            c;
        logic [SL_BITS:0]  m;
        logic              rem;
        logic [SIZE_W-1:0] low_mask;
        c.fl = '0;
        c.sl = v[CLASS0_BITS-1:ALIGN_BITS];
        for (int t = CLASS0_BITS; t < SIZE_W; t++)
        begin
            if (v[t])
            begin
                low_mask = (SIZE_W'(1) << (t - SL_BITS)) - SIZE_W'(1);
                rem      = |(v & low_mask);
                m        = {1'b0, v[t-1 -: SL_BITS]} + {{SL_BITS{1'b0}}, round_up & rem};
                c.fl     = (FL_BITS+1)'(t - CLASS0_BITS + 1 + int'(m[SL_BITS]));
                c.sl     = m[SL_BITS-1:0];
            end
        end
        return c;
    endfunction

    function automatic logic [SL_BITS-1:0] low_sl(input logic [NUM_SL-1:0] x);
        logic [SL_BITS-1:0] r;
        r = '0;
        for (int i = NUM_SL - 1; i >= 0; i--)
        begin
            if (x[i])
            begin
                r = SL_BITS'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [FL_BITS-1:0] low_fl(input logic [NUM_FL-1:0] x);
        logic [FL_BITS-1:0] r;
        r = '0;
        for (int i = NUM_FL - 1; i >= 0; i--)
        begin
            if (x[i])
            begin
                r = FL_BITS'(i);
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/core/tlsf_free_class_index.sv
// tlsf free class index engine: bitmaps, class search and list head table
//
// One beat per cycle in, one result beat out per input beat, in order. The result beat is
// offered once its input beat has passed the input and head read registers: in the first stage
// class mapping and the bitmap search run from the input register into the head table read
// port, in the second the head value, bitmap update and result are formed into the result
// register. The bitmap and head updates of the beat ahead are forwarded, so beats follow each
// other with no gap; while the result is held off the three stages fill, then s_tready drops.
// The head table is a 512-entry single write, single read memory; an entry counts only while
// its class bit is set, so it needs no clearing after reset and the block is ready at once.
module tlsf_free_class_index
    import tfci_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // req_bytes[37:0], block_addr[69:38], next_addr[101:70]
    input  logic [1:0]   s_tuser,   // opcode[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // level_first[4:0], level_second[8:5], addr_out[40:9],
                                    // class_empty[41]
    output logic [1:0]   m_tuser    // status[1:0]
);

    // input stage
    logic                a_valid_reg;
    logic [1:0]          a_op_reg;
    logic [SIZE_W-1:0]   a_size_reg;
    logic [ADDR_W-1:0]   a_blk_reg;
    logic [ADDR_W-1:0]   a_nxt_reg;

    // head read stage
    logic                b_valid_reg;
    logic [1:0]          b_op_reg;
    logic [1:0]          b_st_reg;
    logic [FL_BITS-1:0]  b_fl_reg;
    logic [SL_BITS-1:0]  b_sl_reg;
    logic [ADDR_W-1:0]   b_blk_reg;
    logic [ADDR_W-1:0]   b_nxt_reg;
    logic                b_fwd_reg;
    logic [ADDR_W-1:0]   b_fwd_data_reg;
    logic [ADDR_W-1:0]   mem_q_reg;

    // result stage
    logic                out_valid_reg;
    logic [1:0]          out_st_reg;
    logic [FL_BITS-1:0]  out_fl_reg;
    logic [SL_BITS-1:0]  out_sl_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic                out_empty_reg;

    // bitmaps and head table
    logic [NUM_FL-1:0]   fb_reg;
    logic [NUM_SL-1:0]   sb_reg [NUM_FL];
    logic [ADDR_W-1:0]   head_mem [NUM_FL*NUM_SL];

    logic                a_advance;
    logic                b_advance;
    logic                b_fire;

    // head read stage logic
    logic [IDX_W-1:0]    b_idx;
    logic                b_bit;
    logic [ADDR_W-1:0]   b_head;
    logic [NUM_SL-1:0]   row_new;
    logic [NUM_FL-1:0]   fb_new;
    logic                wr;
    logic                we;
    logic [ADDR_W-1:0]   wdata;
    logic [1:0]          res_st;
    logic [FL_BITS-1:0]  res_fl;
    logic [SL_BITS-1:0]  res_sl;
    logic [ADDR_W-1:0]   res_addr;
    logic                res_empty;

    // input stage logic
    logic [NUM_SL-1:0]   sb_view [NUM_FL];
    logic [NUM_FL-1:0]   fb_view;
    logic [SIZE_W-1:0]   sz_m1;
    logic [SIZE_W-1:0]   s_al;
    logic [SIZE_W-1:0]   s_min;
    logic                too_large;
    class_t              f_cls;
    class_t              i_cls;
    logic [FL_BITS-1:0]  f_fl;
    logic [NUM_SL-1:0]   f_row;
    logic [NUM_FL:0]     hi_mask;
    logic [NUM_FL-1:0]   fmap;
    logic [FL_BITS-1:0]  nf;
    logic [NUM_SL-1:0]   n_row;
    logic [1:0]          a_st;
    logic [FL_BITS-1:0]  a_fl;
    logic [SL_BITS-1:0]  a_sl;
    logic                a_fwd;

    assign b_advance = !out_valid_reg || m_tready;
    assign a_advance = !b_valid_reg || b_advance;
    assign s_tready  = !a_valid_reg || a_advance;
    assign b_fire    = b_valid_reg && b_advance;

    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_st_reg;
    assign m_tdata   = {6'd0, out_empty_reg, out_addr_reg, out_sl_reg, out_fl_reg};

    // head read stage: head value, bitmap update and result

    assign b_idx  = {b_fl_reg, b_sl_reg};
    assign b_bit  = sb_reg[b_fl_reg][b_sl_reg];
    assign b_head = b_bit ? (b_fwd_reg ? b_fwd_data_reg : mem_q_reg) : '0;

    always_comb
    begin
        row_new   = sb_reg[b_fl_reg];
        fb_new    = fb_reg;
        wr        = 1'b0;
        wdata     = b_blk_reg;
        res_st    = ST_OK;
        res_fl    = '0;
        res_sl    = '0;
        res_addr  = '0;
        res_empty = 1'b0;
        case (b_op_reg)
            OP_FIND:
            begin
                if (b_st_reg == ST_TOO_LARGE)
                begin
                    res_st = ST_TOO_LARGE;
                end
                else if (b_st_reg == ST_NO_FREE)
                begin
                    res_st    = ST_NO_FREE;
                    res_fl    = b_fl_reg;
                    res_sl    = b_sl_reg;
                    res_empty = 1'b1;
                end
                else
                begin
                    res_fl   = b_fl_reg;
                    res_sl   = b_sl_reg;
                    res_addr = b_head;
                end
            end
            OP_INSERT:
            begin
                if (b_st_reg == ST_TOO_LARGE)
                begin
                    res_st = ST_TOO_LARGE;
                end
                else
                begin
                    res_fl   = b_fl_reg;
                    res_sl   = b_sl_reg;
                    res_addr = b_head;
                    if (b_blk_reg != '0)
                    begin
                        wr                = 1'b1;
                        row_new[b_sl_reg] = 1'b1;
                        fb_new[b_fl_reg]  = 1'b1;
                    end
                    else
                    begin
                        res_empty = !b_bit;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (b_st_reg == ST_TOO_LARGE)
                begin
                    res_st = ST_TOO_LARGE;
                end
                else
                begin
                    res_fl   = b_fl_reg;
                    res_sl   = b_sl_reg;
                    res_addr = b_head;
                    if (b_blk_reg != '0 && b_head == b_blk_reg)
                    begin
                        wr       = 1'b1;
                        wdata    = b_nxt_reg;
                        res_addr = b_nxt_reg;
                        if (b_nxt_reg == '0)
                        begin
                            row_new[b_sl_reg] = 1'b0;
                            if (row_new == '0)
                            begin
                                fb_new[b_fl_reg] = 1'b0;
                            end
                        end
                    end
                    res_empty = !row_new[b_sl_reg];
                end
            end
            default:
            begin
                res_st = ST_OK;
            end
        endcase
    end

    assign we = wr && b_fire;

    // bitmaps as they stand once the beat ahead has committed
    always_comb
    begin
        for (int i = 0; i < NUM_FL; i++)
        begin
            sb_view[i] = (b_valid_reg && b_fl_reg == FL_BITS'(i)) ? row_new : sb_reg[i];
        end
        fb_view = b_valid_reg ? fb_new : fb_reg;
    end

    // input stage: alignment, class mapping and bitmap search

    assign sz_m1     = a_size_reg - SIZE_W'(1);
    assign s_al      = (sz_m1 | SIZE_W'((1 << ALIGN_BITS) - 1)) + SIZE_W'(1);
    assign s_min     = (s_al < SIZE_W'(MIN_BLOCK)) ? SIZE_W'(MIN_BLOCK) : s_al;
    assign too_large = a_size_reg > SIZE_LIMIT;
    assign f_cls     = map_class(s_min, 1'b1);
    assign i_cls     = map_class(a_size_reg, 1'b0);
    assign f_fl      = f_cls.fl[FL_BITS-1:0];
    assign f_row     = sb_view[f_fl] & ({NUM_SL{1'b1}} << f_cls.sl);
    assign hi_mask   = ~(((NUM_FL+1)'(2) << f_fl) - (NUM_FL+1)'(1));
    assign fmap      = fb_view & hi_mask[NUM_FL-1:0];
    assign nf        = low_fl(fmap);
    assign n_row     = sb_view[nf];

    always_comb
    begin
        a_st = ST_OK;
        a_fl = '0;
        a_sl = '0;
        case (a_op_reg)
            OP_FIND:
            begin
                if (too_large || f_cls.fl[FL_BITS])
                begin
                    a_st = ST_TOO_LARGE;
                end
                else if (f_row != '0)
                begin
                    a_fl = f_fl;
                    a_sl = low_sl(f_row);
                end
                else if (fmap != '0 && n_row != '0)
                begin
                    a_fl = nf;
                    a_sl = low_sl(n_row);
                end
                else
                begin
                    a_st = ST_NO_FREE;
                    a_fl = f_fl;
                    a_sl = f_cls.sl;
                end
            end
            OP_INSERT, OP_REMOVE:
            begin
                if (i_cls.fl[FL_BITS])
                begin
                    a_st = ST_TOO_LARGE;
                end
                else
                begin
                    a_fl = i_cls.fl[FL_BITS-1:0];
                    a_sl = i_cls.sl;
                end
            end
            default:
            begin
                a_st = ST_OK;
            end
        endcase
    end

    assign a_fwd = we && (b_idx == {a_fl, a_sl});

    // head table
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            head_mem[b_idx] <= wdata;
        end
        if (a_advance && a_valid_reg)
        begin
            mem_q_reg <= head_mem[{a_fl, a_sl}];
        end
    end

    // control and bitmaps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            fb_reg        <= '0;
            for (int i = 0; i < NUM_FL; i++)
            begin
                sb_reg[i] <= '0;
            end
        end
        else
        begin
            if (s_tready)
            begin
                a_valid_reg <= s_tvalid;
            end
            if (a_advance)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (b_advance)
            begin
                out_valid_reg <= b_valid_reg;
            end
            if (b_fire)
            begin
                sb_reg[b_fl_reg] <= row_new;
                fb_reg           <= fb_new;
            end
        end
    end

    // beat payloads
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            a_op_reg   <= s_tuser;
            a_size_reg <= s_tdata[37:0];
            a_blk_reg  <= s_tdata[69:38];
            a_nxt_reg  <= s_tdata[101:70];
        end
        if (a_advance && a_valid_reg)
        begin
            b_op_reg       <= a_op_reg;
            b_st_reg       <= a_st;
            b_fl_reg       <= a_fl;
            b_sl_reg       <= a_sl;
            b_blk_reg      <= a_blk_reg;
            b_nxt_reg      <= a_nxt_reg;
            b_fwd_reg      <= a_fwd;
            b_fwd_data_reg <= wdata;
        end
        if (b_fire)
        begin
            out_st_reg    <= res_st;
            out_fl_reg    <= res_fl;
            out_sl_reg    <= res_sl;
            out_addr_reg  <= res_addr;
            out_empty_reg <= res_empty;
        end
    end

endmodule
